// ----- rtl/core/lidar_motion_deskew_defines.svh -----
// Assertion macros for the deskew RTL.
`ifndef LIDAR_MOTION_DESKEW_DEFINES_SVH
`define LIDAR_MOTION_DESKEW_DEFINES_SVH

// Same-cycle implication, reset masked.
`define LMD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset masked.
`define LMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/lmd_pkg.sv -----
// Shared types, constants and helper functions of the deskew block.
package lmd_pkg;

    localparam int DW  = 64;   // datapath width
    localparam int BW  = 34;   // narrow multiplier operand width
    localparam int AW  = 34;   // CORDIC angle accumulator width
    localparam int FW  = 32;   // frame velocity / rate width
    localparam int PW  = 25;   // point coordinate width
    localparam int SPW = 17;   // sweep time width
    localparam int VW  = 24;   // velocity register width
    localparam int RW  = 21;   // rate register width
    localparam int CFG_DW = 24;
    localparam int CFG_IW = 3;

    localparam int DEF_FRAC_BITS     = 16;
    localparam int DEF_CORDIC_STAGES = 16;

    localparam logic [CFG_IW-1:0] CFG_SWEEP_TIME  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_VEL_X       = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_VEL_Y       = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_VEL_Z       = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_RATE_ROLL   = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_RATE_PITCH  = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_RATE_YAW    = 3'd6;

    localparam logic [SPW-1:0]       SWEEP_TIME_RST = 17'd6554;
    localparam logic [31:0]          HALF_TURN  = 32'h8000_0000;
    localparam logic [31:0]          DROP_BAM   = 32'd59652324;
    localparam logic signed [BW-1:0] RAD_TO_BAM = 34'sd683565276;
    localparam logic signed [DW-1:0] GAIN_Q30   = 64'sd652032875;

    typedef struct packed {
        logic go;
        logic vec;   // 1: vectoring (atan2), 0: rotation (sin/cos)
    } t_cor_req;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic signed [AW-1:0] lmd_atan(input logic [4:0] i);
        logic signed [AW-1:0] r;
        unique case (i)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            5'd20: r = 34'sd652;
            5'd21: r = 34'sd326;
            5'd22: r = 34'sd163;
            5'd23: r = 34'sd81;
            5'd24: r = 34'sd41;
            5'd25: r = 34'sd20;
            5'd26: r = 34'sd10;
            5'd27: r = 34'sd5;
            5'd28: r = 34'sd3;
            5'd29: r = 34'sd1;
            5'd30: r = 34'sd1;
            5'd31: r = 34'sd0;
        endcase
        return r;
    endfunction

    // right shift, rounding half up
    function automatic logic signed [DW-1:0] lmd_rnd(input logic signed [DW-1:0] v,
                                                     input int sh);
        logic signed [DW-1:0] h;
        h = 64'sd1 <<< (sh - 1);
        return (v + h) >>> sh;
    endfunction

    function automatic logic signed [PW-1:0] lmd_sat(input logic signed [DW-1:0] v);
        logic signed [PW-1:0] r;
        if (v > 64'sd16777215)
            r = 25'sd16777215;
        else if (v < -64'sd16777216)
            r = -25'sd16777216;
        else
            r = PW'(v);
        return r;
    endfunction

endpackage

// ----- rtl/core/lmd_mul.sv -----
// Bit-serial signed multiplier, one bit of the narrow operand per cycle.
module lmd_mul
    import lmd_pkg::*;
#(
    parameter int AWID = DW,
    parameter int BWID = BW
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_go,
    input  logic signed [AWID-1:0] i_a,
    input  logic signed [BWID-1:0] i_b,
    output logic                   o_done,
    output logic signed [AWID-1:0] o_prod
);
    localparam int CNTW = $clog2(BWID);

    logic signed [AWID-1:0] r_a, r_p;
    logic signed [BWID-1:0] r_b;
    logic [CNTW-1:0]        r_cnt;
    logic                   r_run, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_a   <= i_a;
                r_b   <= i_b;
                r_p   <= '0;
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                // sign bit of b carries negative weight
                if (r_b[0])
                    r_p <= (r_cnt == CNTW'(BWID - 1)) ? r_p - r_a : r_p + r_a;
                r_a   <= r_a <<< 1;
                r_b   <= r_b >>> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(BWID - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;
endmodule

// ----- rtl/core/lmd_cordic.sv -----
// Iterative CORDIC, one stage per cycle: rotation (sin/cos) or vectoring (atan2).
module lmd_cordic
    import lmd_pkg::*;
#(
    parameter int STAGES = DEF_CORDIC_STAGES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cor_req             i_req,
    input  logic signed [DW-1:0] i_x,
    input  logic signed [DW-1:0] i_y,
    input  logic [31:0]          i_ang,
    output logic                 o_done,
    output logic signed [DW-1:0] o_x,
    output logic signed [DW-1:0] o_y,
    output logic [31:0]          o_ang
);
    localparam int IW = $clog2(STAGES + 1);

    logic signed [DW-1:0] r_x, r_y;
    logic signed [AW-1:0] r_z;
    logic [IW-1:0]        r_i;
    logic                 r_run, r_done, r_vec, r_neg, r_base, r_zero;

    logic signed [DW-1:0] w_dx, w_dy;
    logic signed [AW-1:0] w_at;
    logic                 w_pos;
    logic [31:0]          w_a2;
    logic                 w_fold;

    assign w_dx  = r_y >>> r_i;
    assign w_dy  = r_x >>> r_i;
    assign w_at  = lmd_atan(5'(r_i));
    assign w_pos = r_vec ? r_y[DW-1] : !r_z[AW-1];

    assign w_fold = (i_ang[31:30] == 2'b01) || (i_ang[31:30] == 2'b10);
    assign w_a2   = w_fold ? i_ang - HALF_TURN : i_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_vec <= i_req.vec;
                r_i   <= '0;
                r_run <= 1'b1;
                r_z   <= '0;
                if (i_req.vec) begin
                    r_zero <= (i_x == '0) && (i_y == '0);
                    r_base <= i_x[DW-1];
                    r_neg  <= 1'b0;
                    r_x    <= (i_x[DW-1] ? -i_x : i_x) <<< 20;
                    r_y    <= (i_x[DW-1] ? -i_y : i_y) <<< 20;
                end else begin
                    r_zero <= 1'b0;
                    r_base <= 1'b0;
                    r_neg  <= w_fold;
                    r_x    <= GAIN_Q30;
                    r_y    <= '0;
                    r_z    <= AW'($signed(w_a2));
                end
            end else if (r_run) begin
                if (w_pos) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_at;
                end
                r_i <= r_i + 1'b1;
                if (r_i == IW'(STAGES - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_neg ? -r_x : r_x;
    assign o_y    = r_neg ? -r_y : r_y;
    assign o_ang  = r_zero ? 32'd0 : (r_base ? HALF_TURN : 32'd0) + r_z[31:0];
endmodule

// ----- rtl/core/lidar_motion_deskew.sv -----
// Top level of the LiDAR sweep motion deskew block.
//
// Input channel: i_valid / o_stall carry one point request (x, y, z, starts_cloud).
// A request is taken when i_valid is high and o_stall is low; o_stall is high
// while a point is in work, so points are handled one at a time.
// A start point sets the start frame (atan2, sin/cos) and rotates the
// configured velocity and rates into it; it produces no output request.
// Other points are rotated into the start frame, dropped within 5 degrees of
// the start azimuth, otherwise corrected and sent on o_valid / i_stall.
// Work runs on one bit-serial multiplier and one iterative CORDIC, sequenced
// step by step. Start point: 8 products + 2 CORDIC calls.
// Other point: 30 products + 4 CORDIC calls; a dropped point ends after
// 4 products + 1 CORDIC call.
// The result sits in an output register: the next point is accepted while it
// waits, and the core only holds in its final step if the register is still
// full when the next result is ready. The receiver may stall freely.
// Reset (synchronous, active low) restores the identity frame, zero motion,
// sweep time 6554 and empties the output register.
// Configuration is a plain write port (index 0..6); writes are for idle time.
module lidar_motion_deskew
    import lmd_pkg::*;
#(
    parameter int FRAC_BITS     = DEF_FRAC_BITS,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IW-1:0]       i_cfg_index,
    input  logic [CFG_DW-1:0]       i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [PW-1:0]    i_point_x,
    input  logic signed [PW-1:0]    i_point_y,
    input  logic signed [PW-1:0]    i_point_z,
    input  logic                    i_starts_cloud,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [PW-1:0]    o_out_x,
    output logic signed [PW-1:0]    o_out_y,
    output logic signed [PW-1:0]    o_out_z
);
`include "lidar_motion_deskew_defines.svh"

    localparam int CW = FRAC_BITS + 2;   // start cos/sin width

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_DONE} t_state;
    typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} t_acc;
    typedef enum logic [5:0] {
        ST_SVEC, ST_SROT, ST_FV0A, ST_FV0B, ST_FV1A, ST_FV1B,
        ST_FR0A, ST_FR0B, ST_FR1A, ST_FR1B,
        ST_XA, ST_XB, ST_YA, ST_YB, ST_AVEC, ST_T,
        ST_E0M, ST_E0R, ST_E0C, ST_E1M, ST_E1R, ST_E1C, ST_E2M, ST_E2R, ST_E2C,
        ST_RXA, ST_RXB, ST_RXC, ST_RXD, ST_RYA, ST_RYB, ST_RYC, ST_RYD,
        ST_RZA, ST_RZB, ST_RZC, ST_RZD, ST_VX, ST_VY, ST_VZ,
        ST_OXA, ST_OXB, ST_OYA, ST_OYB
    } t_step;

    // configuration
    logic [SPW-1:0]       r_period;
    logic signed [VW-1:0] r_vel  [3];
    logic signed [RW-1:0] r_rate [3];

    // frame state
    logic signed [CW-1:0] r_c, r_s;
    logic signed [FW-1:0] r_fv [3];
    logic signed [FW-1:0] r_fr [3];

    // working set
    t_state               r_state;
    t_step                r_step;
    logic                 r_is_start;
    logic signed [DW-1:0] r_px, r_py;
    logic signed [DW-1:0] r_x, r_y, r_z, r_tmp, r_acc;
    logic signed [BW-1:0] r_t;
    logic signed [BW-1:0] r_ec [3];    // cos of Euler angles, Q30
    logic signed [BW-1:0] r_es [3];    // sin of Euler angles, Q30
    logic [31:0]          r_ang;

    // output register
    logic                 r_ov;
    logic signed [PW-1:0] r_ox, r_oy, r_oz;

    logic signed [DW-1:0] w_mul_a, w_prod, w_sum, w_rf, w_r30, w_rcs;
    logic signed [BW-1:0] w_mul_b;
    t_acc                 w_mode;
    logic                 w_is_cor, w_mul_done, w_cor_done, w_drop;
    t_cor_req             w_cor_req;
    logic signed [DW-1:0] w_cx, w_cy, w_cor_ix, w_cor_iy;
    logic [31:0]          w_cor_ang;
    t_step                w_next;
    t_state               n_wait;

    assign w_is_cor = (r_step == ST_SVEC) || (r_step == ST_SROT) || (r_step == ST_AVEC) ||
                      (r_step == ST_E0C) || (r_step == ST_E1C) || (r_step == ST_E2C);
    assign w_cor_req.go  = (r_state == S_ISSUE) && w_is_cor;
    assign w_cor_req.vec = (r_step == ST_SVEC) || (r_step == ST_AVEC);
    assign w_cor_ix = (r_step == ST_SVEC) ? r_px : r_x;
    assign w_cor_iy = (r_step == ST_SVEC) ? r_py : r_y;
    assign w_next   = t_step'(6'(r_step) + 6'd1);

    // multiplier operand selection per step
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        w_mode  = ACC_LOAD;
        unique case (r_step)
            ST_FV0A: begin w_mul_a = DW'(r_vel[0]);  w_mul_b = BW'(r_c); end
            ST_FV0B: begin w_mul_a = DW'(r_vel[1]);  w_mul_b = BW'(r_s); w_mode = ACC_ADD; end
            ST_FV1A: begin w_mul_a = DW'(r_vel[1]);  w_mul_b = BW'(r_c); end
            ST_FV1B: begin w_mul_a = DW'(r_vel[0]);  w_mul_b = BW'(r_s); w_mode = ACC_SUB; end
            ST_FR0A: begin w_mul_a = DW'(r_rate[0]); w_mul_b = BW'(r_c); end
            ST_FR0B: begin w_mul_a = DW'(r_rate[1]); w_mul_b = BW'(r_s); w_mode = ACC_ADD; end
            ST_FR1A: begin w_mul_a = DW'(r_rate[1]); w_mul_b = BW'(r_c); end
            ST_FR1B: begin w_mul_a = DW'(r_rate[0]); w_mul_b = BW'(r_s); w_mode = ACC_SUB; end
            ST_XA:   begin w_mul_a = r_px; w_mul_b = BW'(r_c); end
            ST_XB:   begin w_mul_a = r_py; w_mul_b = BW'(r_s); w_mode = ACC_ADD; end
            ST_YA:   begin w_mul_a = r_py; w_mul_b = BW'(r_c); end
            ST_YB:   begin w_mul_a = r_px; w_mul_b = BW'(r_s); w_mode = ACC_SUB; end
            ST_T: begin
                w_mul_a = DW'({1'b0, r_ang}) - DW'({1'b0, HALF_TURN});
                w_mul_b = BW'({1'b0, r_period});
            end
            ST_E0M:  begin w_mul_a = DW'(r_fr[0]); w_mul_b = r_t; end
            ST_E1M:  begin w_mul_a = DW'(r_fr[1]); w_mul_b = r_t; end
            ST_E2M:  begin w_mul_a = DW'(r_fr[2]); w_mul_b = r_t; end
            ST_E0R, ST_E1R, ST_E2R: begin w_mul_a = r_tmp; w_mul_b = RAD_TO_BAM; end
            ST_RXA:  begin w_mul_a = r_y; w_mul_b = r_ec[0]; end
            ST_RXB:  begin w_mul_a = r_z; w_mul_b = r_es[0]; w_mode = ACC_SUB; end
            ST_RXC:  begin w_mul_a = r_y; w_mul_b = r_es[0]; end
            ST_RXD:  begin w_mul_a = r_z; w_mul_b = r_ec[0]; w_mode = ACC_ADD; end
            ST_RYA:  begin w_mul_a = r_x; w_mul_b = r_ec[1]; end
            ST_RYB:  begin w_mul_a = r_z; w_mul_b = r_es[1]; w_mode = ACC_ADD; end
            ST_RYC:  begin w_mul_a = r_z; w_mul_b = r_ec[1]; end
            ST_RYD:  begin w_mul_a = r_x; w_mul_b = r_es[1]; w_mode = ACC_SUB; end
            ST_RZA:  begin w_mul_a = r_x; w_mul_b = r_ec[2]; end
            ST_RZB:  begin w_mul_a = r_y; w_mul_b = r_es[2]; w_mode = ACC_SUB; end
            ST_RZC:  begin w_mul_a = r_x; w_mul_b = r_es[2]; end
            ST_RZD:  begin w_mul_a = r_y; w_mul_b = r_ec[2]; w_mode = ACC_ADD; end
            ST_VX:   begin w_mul_a = DW'(r_fv[0]); w_mul_b = r_t; end
            ST_VY:   begin w_mul_a = DW'(r_fv[1]); w_mul_b = r_t; end
            ST_VZ:   begin w_mul_a = DW'(r_fv[2]); w_mul_b = r_t; end
            ST_OXA:  begin w_mul_a = r_x; w_mul_b = BW'(r_c); end
            ST_OXB:  begin w_mul_a = r_y; w_mul_b = BW'(r_s); w_mode = ACC_SUB; end
            ST_OYA:  begin w_mul_a = r_x; w_mul_b = BW'(r_s); end
            ST_OYB:  begin w_mul_a = r_y; w_mul_b = BW'(r_c); w_mode = ACC_ADD; end
            default: ;   // CORDIC steps
        endcase
    end

    lmd_mul #(.AWID(DW), .BWID(BW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    ((r_state == S_ISSUE) && !w_is_cor),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    lmd_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_cor_req),
        .i_x     (w_cor_ix),
        .i_y     (w_cor_iy),
        .i_ang   (r_ang),
        .o_done  (w_cor_done),
        .o_x     (w_cx),
        .o_y     (w_cy),
        .o_ang   (w_cor_ang)
    );

    always_comb begin
        unique case (w_mode)
            ACC_ADD: w_sum = r_acc + w_prod;
            ACC_SUB: w_sum = r_acc - w_prod;
            default: w_sum = w_prod;
        endcase
    end

    assign w_rf  = lmd_rnd(w_sum, FRAC_BITS);
    assign w_r30 = lmd_rnd(w_sum, 30);
    assign w_rcs = lmd_rnd(w_cx, 30 - FRAC_BITS);
    // within 5 degrees of the start azimuth on either side
    assign w_drop = (w_cor_ang < DROP_BAM) ||
                    (({1'b1, 32'd0} - {1'b0, w_cor_ang}) < {1'b0, DROP_BAM});

    // state after a finished step: start and dropped points end early
    always_comb begin
        n_wait = S_ISSUE;
        if ((r_step == ST_FR1B) || ((r_step == ST_AVEC) && w_drop))
            n_wait = S_IDLE;
        else if (r_step == ST_OYB)
            n_wait = S_DONE;
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= ST_SVEC;
            r_is_start <= 1'b0;
            r_ov       <= 1'b0;
            r_period   <= SWEEP_TIME_RST;
            r_vel[0]   <= '0;
            r_vel[1]   <= '0;
            r_vel[2]   <= '0;
            r_rate[0]  <= '0;
            r_rate[1]  <= '0;
            r_rate[2]  <= '0;
            r_c        <= CW'(1) <<< FRAC_BITS;
            r_s        <= '0;
            r_fv[0]    <= '0;
            r_fv[1]    <= '0;
            r_fv[2]    <= '0;
            r_fr[0]    <= '0;
            r_fr[1]    <= '0;
            r_fr[2]    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SWEEP_TIME:  r_period  <= i_cfg_data[SPW-1:0];
                    CFG_VEL_X:       r_vel[0]  <= i_cfg_data[VW-1:0];
                    CFG_VEL_Y:       r_vel[1]  <= i_cfg_data[VW-1:0];
                    CFG_VEL_Z:       r_vel[2]  <= i_cfg_data[VW-1:0];
                    CFG_RATE_ROLL:   r_rate[0] <= i_cfg_data[RW-1:0];
                    CFG_RATE_PITCH:  r_rate[1] <= i_cfg_data[RW-1:0];
                    CFG_RATE_YAW:    r_rate[2] <= i_cfg_data[RW-1:0];
                    default: ;
                endcase
            end

            // in S_DONE the reload below decides the flag
            if (r_ov && !i_stall && (r_state != S_DONE))
                r_ov <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_px       <= DW'(i_point_x);
                        r_py       <= DW'(i_point_y);
                        r_z        <= DW'(i_point_z);
                        r_is_start <= i_starts_cloud;
                        r_step     <= i_starts_cloud ? ST_SVEC : ST_XA;
                        r_state    <= S_ISSUE;
                    end
                end
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_mul_done || w_cor_done) begin
                        r_acc   <= w_sum;
                        r_step  <= w_next;
                        r_state <= n_wait;
                        unique case (r_step)
                            ST_SVEC: r_ang <= w_cor_ang;
                            ST_SROT: begin
                                r_c     <= CW'(w_rcs);
                                r_s     <= CW'(lmd_rnd(w_cy, 30 - FRAC_BITS));
                                r_fv[2] <= FW'(r_vel[2]);
                                r_fr[2] <= FW'(r_rate[2]);
                            end
                            ST_FV0B: r_fv[0] <= FW'(w_rf);
                            ST_FV1B: r_fv[1] <= FW'(w_rf);
                            ST_FR0B: r_fr[0] <= FW'(w_rf);
                            ST_FR1B: r_fr[1] <= FW'(w_rf);   // start point ends here
                            ST_XB: r_x <= w_rf;
                            ST_YB: r_y <= w_rf;
                            ST_AVEC: r_ang <= w_cor_ang;
                            ST_T: r_t <= BW'(lmd_rnd(w_sum, 32));
                            ST_E0M, ST_E1M, ST_E2M: r_tmp <= w_rf;
                            ST_E0R, ST_E1R, ST_E2R: r_ang <= w_rf[31:0];
                            ST_E0C: begin r_ec[0] <= BW'(w_cx); r_es[0] <= BW'(w_cy); end
                            ST_E1C: begin r_ec[1] <= BW'(w_cx); r_es[1] <= BW'(w_cy); end
                            ST_E2C: begin r_ec[2] <= BW'(w_cx); r_es[2] <= BW'(w_cy); end
                            ST_RXB, ST_RYB, ST_RZB: r_tmp <= w_r30;
                            ST_RXD: begin r_z <= w_r30; r_y <= r_tmp; end
                            ST_RYD: begin r_z <= w_r30; r_x <= r_tmp; end
                            ST_RZD: begin r_y <= w_r30; r_x <= r_tmp; end
                            ST_VX: r_x <= r_x + w_rf;
                            ST_VY: r_y <= r_y + w_rf;
                            ST_VZ: r_z <= r_z + w_rf;
                            ST_OXB: r_tmp <= w_rf;
                            ST_OYB: r_y <= w_rf;
                            default: ;   // partial products stay in the accumulator
                        endcase
                    end
                end
                S_DONE: begin
                    if (!r_ov || !i_stall) begin
                        r_ox    <= lmd_sat(r_tmp);
                        r_oy    <= lmd_sat(r_y);
                        r_oz    <= lmd_sat(r_z);
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_out_x = r_ox;
    assign o_out_y = r_oy;
    assign o_out_z = r_oz;

    `LMD_ASSERT_NOW(a_unit_done_in_wait, i_clk, i_rst_n, (w_mul_done || w_cor_done), (r_state == S_WAIT), "unit finished outside wait state")
    `LMD_ASSERT_NOW(a_one_unit_done, i_clk, i_rst_n, w_mul_done, !w_cor_done, "multiplier and CORDIC finished together")
    `LMD_ASSERT_NEXT(a_start_no_result, i_clk, i_rst_n, (r_state == S_WAIT && r_step == ST_FR1B && w_mul_done), (r_state == S_IDLE && r_is_start), "start point did not end quietly")
    `LMD_ASSERT_NOW(a_rise_from_done, i_clk, i_rst_n, $rose(o_valid), ($past(r_state) == S_DONE), "result appeared without a finished point")

endmodule

// ----- tb/lmd_deskew_checker.sv -----
// Checker for the deskew block: predicts corrected points and compares results.
module lmd_deskew_checker
    import lmd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IW-1:0]    i_cfg_index,
    input  logic [CFG_DW-1:0]    i_cfg_data,
    input  logic                 i_pt_valid,
    input  logic                 i_pt_stall,
    input  logic signed [PW-1:0] i_px,
    input  logic signed [PW-1:0] i_py,
    input  logic signed [PW-1:0] i_pz,
    input  logic                 i_starts_cloud,
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  logic signed [PW-1:0] i_rx,
    input  logic signed [PW-1:0] i_ry,
    input  logic signed [PW-1:0] i_rz,
    output int                   o_errors,
    output int                   o_pending
);

    localparam int     NFRAC  = 16;
    localparam int     NSTAGE = 16;
    localparam longint TURN   = 64'sh1_0000_0000;
    localparam longint HALF   = 64'sh8000_0000;
    localparam longint DROP   = 64'sd59652324;
    localparam longint ATAN_TAB [0:31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    typedef struct packed {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] z;
    } point_t;

    point_t corrected_q[$];

    // configuration and latched frame
    longint sweep_time;
    longint vel[3];
    longint rate[3];
    longint org_cos, org_sin;
    longint frame_vel[3];
    longint frame_rate[3];

    function automatic longint sx_w(longint v, int w);
        return (v <<< (64 - w)) >>> (64 - w);
    endfunction

    function automatic longint rsh(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp25(longint v);
        if (v > 64'sd16777215)
            return 64'sd16777215;
        else if (v < -64'sd16777216)
            return -64'sd16777216;
        return v;
    endfunction

    // rotation mode, Q30 cos/sin of a binary angle
    function automatic void cos_sin(input logic [31:0] ang, output longint c,
                                    output longint s);
        longint x, y, z, dx, dy;
        bit flip;
        x = 64'sd652032875;
        y = 0;
        flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
        if (flip)
            ang = ang - 32'h8000_0000;
        z = ang[31] ? longint'({32'd0, ang}) - TURN : longint'({32'd0, ang});
        for (int i = 0; i < NSTAGE; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // vectoring mode, binary angle of (x, y)
    function automatic logic [31:0] azimuth(longint x, longint y);
        longint base, z, dx, dy;
        base = 0;
        z = 0;
        if (x == 0 && y == 0)
            return 32'd0;
        if (x < 0) begin
            x = -x; y = -y; base = HALF;
        end
        x = x <<< 20;
        y = y <<< 20;
        for (int i = 0; i < NSTAGE; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
        end
        return 32'(base + z);
    endfunction

    function automatic logic [31:0] to_bam(longint r);
        return 32'(rsh(r * 64'sd683565276, NFRAC));
    endfunction

    // one point through the deskew; start points only latch the frame
    function automatic void deskew_point(input longint px, input longint py,
                                         input longint pz, input bit starts,
                                         output bit has_out, output point_t res);
        longint c, s, x, y, z, t, a, nx, ny, nz;
        longint cr[3], sr[3];
        longint cq, sq;
        c = org_cos;
        s = org_sin;
        has_out = 0;
        res = '0;
        if (starts) begin
            cos_sin(azimuth(px, py), cq, sq);
            c = rsh(cq, 30 - NFRAC);
            s = rsh(sq, 30 - NFRAC);
            org_cos = c;
            org_sin = s;
            frame_vel[0]  = rsh(c * vel[0] + s * vel[1], NFRAC);
            frame_vel[1]  = rsh(c * vel[1] - s * vel[0], NFRAC);
            frame_vel[2]  = vel[2];
            frame_rate[0] = rsh(c * rate[0] + s * rate[1], NFRAC);
            frame_rate[1] = rsh(c * rate[1] - s * rate[0], NFRAC);
            frame_rate[2] = rate[2];
            return;
        end
        x = rsh(c * px + s * py, NFRAC);
        y = rsh(c * py - s * px, NFRAC);
        z = pz;
        a = longint'({32'd0, azimuth(x, y)});
        if (a < DROP || TURN - a < DROP)
            return;
        t = rsh((a - HALF) * sweep_time, 32);
        for (int k = 0; k < 3; k++)
            cos_sin(to_bam(rsh(frame_rate[k] * t, NFRAC)), cr[k], sr[k]);
        // roll, pitch, yaw in that order
        ny = rsh(cr[0] * y - sr[0] * z, 30);
        nz = rsh(sr[0] * y + cr[0] * z, 30);
        y = ny; z = nz;
        nx = rsh(cr[1] * x + sr[1] * z, 30);
        nz = rsh(cr[1] * z - sr[1] * x, 30);
        x = nx; z = nz;
        nx = rsh(cr[2] * x - sr[2] * y, 30);
        ny = rsh(sr[2] * x + cr[2] * y, 30);
        x = nx; y = ny;
        x += rsh(frame_vel[0] * t, NFRAC);
        y += rsh(frame_vel[1] * t, NFRAC);
        z += rsh(frame_vel[2] * t, NFRAC);
        nx = rsh(c * x - s * y, NFRAC);
        ny = rsh(s * x + c * y, NFRAC);
        res.x = PW'(clamp25(nx));
        res.y = PW'(clamp25(ny));
        res.z = PW'(clamp25(z));
        has_out = 1;
    endfunction

    always @(posedge i_clk) begin
        point_t want, got;
        bit     has;
        if (!i_rst_n) begin
            o_errors = 0;
            sweep_time = 6554;
            for (int k = 0; k < 3; k++) begin
                vel[k] = 0; rate[k] = 0; frame_vel[k] = 0; frame_rate[k] = 0;
            end
            org_cos = 64'sd1 <<< NFRAC;
            org_sin = 0;
            corrected_q.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                got = '{i_rx, i_ry, i_rz};
                if (corrected_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result x=%0d y=%0d z=%0d",
                             $time, i_rx, i_ry, i_rz);
                end else begin
                    want = corrected_q.pop_front();
                    if (want.x !== got.x || want.y !== got.y || want.z !== got.z) begin
                        o_errors++;
                        $display("%0t: mismatch exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                 $time, want.x, want.y, want.z, got.x, got.y, got.z);
                    end
                end
            end
            if (i_pt_valid && !i_pt_stall) begin
                deskew_point(i_px, i_py, i_pz, i_starts_cloud, has, want);
                if (has)
                    corrected_q = {corrected_q, want};
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SWEEP_TIME:  sweep_time = longint'(i_cfg_data[SPW-1:0]);
                    CFG_VEL_X:       vel[0]  = sx_w(longint'(i_cfg_data), VW);
                    CFG_VEL_Y:       vel[1]  = sx_w(longint'(i_cfg_data), VW);
                    CFG_VEL_Z:       vel[2]  = sx_w(longint'(i_cfg_data), VW);
                    CFG_RATE_ROLL:   rate[0] = sx_w(longint'(i_cfg_data), RW);
                    CFG_RATE_PITCH:  rate[1] = sx_w(longint'(i_cfg_data), RW);
                    CFG_RATE_YAW:    rate[2] = sx_w(longint'(i_cfg_data), RW);
                    default: ;
                endcase
            end
        end
        o_pending = corrected_q.size();
    end

endmodule

// ----- tb/tb_lidar_motion_deskew.sv -----
// Top of the deskew testbench: clock, reset, point stimulus and verdict.
module tb_lidar_motion_deskew;
    import lmd_pkg::*;

    localparam int STALL_LIMIT = 20000;  // cycles without any request moving
    localparam int DRAIN_WAIT  = 1500;   // time for the longest point to finish
    localparam int HOLD_LEN    = 4000;   // receiver hold-off to back up the input
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 118;

    localparam longint P_MAX = 64'sd16777215;
    localparam longint P_MIN = -64'sd16777216;
    localparam longint ONE_M = 64'sd65536;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IW-1:0]    i_cfg_index = '0;
    logic [CFG_DW-1:0]    i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [PW-1:0] i_point_x = '0;
    logic signed [PW-1:0] i_point_y = '0;
    logic signed [PW-1:0] i_point_z = '0;
    logic                 i_starts_cloud = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [PW-1:0] o_out_x, o_out_y, o_out_z;

    int errors, pending;
    bit calm = 1'b0;        // no idling on either side while set
    int hold_asks = 0;      // bumped by the stimulus to request a hold-off
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    always #10 i_clk = ~i_clk;

    lidar_motion_deskew i_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .o_stall, .i_point_x, .i_point_y, .i_point_z, .i_starts_cloud,
        .o_valid, .i_stall, .o_out_x, .o_out_y, .o_out_z
    );

    lmd_deskew_checker i_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_pt_valid(i_valid), .i_pt_stall(o_stall),
        .i_px(i_point_x), .i_py(i_point_y), .i_pz(i_point_z),
        .i_starts_cloud,
        .i_res_valid(o_valid), .i_res_stall(i_stall),
        .i_rx(o_out_x), .i_ry(o_out_y), .i_rz(o_out_z),
        .o_errors(errors), .o_pending(pending)
    );

    // Receiver: random stalls, or a long hold-off when the stimulus asks.
    always @(negedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(0, 99) < 11);
        end
    end

    // Watchdog: any request moving on either channel resets the count.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one point request and hold it until taken. Entered at a falling edge.
    task automatic send_point(longint x, longint y, longint z, bit starts);
        bit took;
        while (!calm && $urandom_range(0, 99) < 11) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_point_x      <= PW'(x);
        i_point_y      <= PW'(y);
        i_point_z      <= PW'(z);
        i_starts_cloud <= starts;
        // o_stall only moves at the rising edge, so it is stable here
        do begin
            took = !o_stall;
            @(negedge i_clk);
        end while (!took);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, longint val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DW'(val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic write_motion(longint per, longint vx, longint vy, longint vz,
                                longint rr, longint rp, longint ry);
        write_reg(CFG_SWEEP_TIME, per);
        write_reg(CFG_VEL_X, vx);
        write_reg(CFG_VEL_Y, vy);
        write_reg(CFG_VEL_Z, vz);
        write_reg(CFG_RATE_ROLL, rr);
        write_reg(CFG_RATE_PITCH, rp);
        write_reg(CFG_RATE_YAW, ry);
    endtask

    // Drain: all results in, then let a dropped or start point finish.
    task automatic settle();
        i_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    function automatic longint pick_coord();
        case ($urandom_range(0, 4))
            0, 1:    return longint'(signed'(PW'($urandom)));         // full range
            2:       return longint'($urandom_range(0, 2 << 20)) - (1 << 20);
            3:       return longint'($urandom_range(0, 200)) * ONE_M / 2 - 100 * ONE_M / 2;
            default: return $urandom_range(0, 1) ? P_MAX : P_MIN;
        endcase
    endfunction

    function automatic longint pick_signed(longint lim);
        return longint'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    initial begin
        int sent, pts;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: before any start the identity frame and zero motion hold.
        send_point(10 * ONE_M, 20 * ONE_M, ONE_M, 1'b0);
        send_point(0, 0, 5, 1'b0);                       // origin: dropped
        send_point(P_MAX, P_MAX, P_MAX, 1'b0);
        send_point(P_MIN, P_MIN, P_MIN, 1'b0);
        send_point(P_MAX, P_MIN, 0, 1'b0);
        send_point(10 * ONE_M, 100, 0, 1'b0);            // near start azimuth
        send_point(0, 0, 0, 1'b1);                       // start at origin
        send_point(-ONE_M, 3 * ONE_M, 2 * ONE_M, 1'b0);
        send_point(0, 3 * ONE_M, 0, 1'b1);
        send_point(0, 5 * ONE_M, 0, 1'b0);               // on start azimuth
        send_point(P_MIN, 0, P_MAX, 1'b0);
        settle();

        // Extremes: the bench's longest sweep, top velocity and rates, saturating sums.
        write_motion(65536, 4194304, 4194304, 4194304, 524288, 524288, 524288);
        send_point(-ONE_M, -ONE_M, 0, 1'b1);
        send_point(P_MAX, -5 * ONE_M, P_MAX, 1'b0);
        send_point(-P_MAX, 7 * ONE_M, P_MIN, 1'b0);
        send_point(0, -20 * ONE_M, ONE_M, 1'b0);
        send_point(0, 0, 0, 1'b0);
        settle();

        // Opposite extremes written mid-sweep: old frame stays until next start.
        write_motion(0, -4194304, -4194304, -4194304, -524288, -524288, -524288);
        send_point(4 * ONE_M, -9 * ONE_M, ONE_M, 1'b0);
        send_point(P_MIN, P_MAX, P_MIN, 1'b0);
        send_point(3 * ONE_M, 2 * ONE_M, 0, 1'b1);
        send_point(-8 * ONE_M, 2 * ONE_M, -ONE_M, 1'b0);
        send_point(P_MAX, P_MAX, 0, 1'b0);
        settle();

        // Random sweeps, one motion setting per phase.
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: write_motion(65536, 4194304, -4194304, 4194304, -524288, 524288, -524288);
                1: write_motion(0, 0, 0, 0, 0, 0, 0);
                2: write_motion(6554, pick_signed(200000), pick_signed(200000),
                                pick_signed(50000), pick_signed(30000),
                                pick_signed(30000), pick_signed(200000));
                default: write_motion($urandom_range(0, 65536), pick_signed(4194304),
                                      pick_signed(4194304), pick_signed(4194304),
                                      pick_signed(524288), pick_signed(524288),
                                      pick_signed(524288));
            endcase
            calm = (ph == 3);
            if (ph == 5)
                hold_asks++;
            sent = 0;
            // sometimes keep the previous frame for a few points
            if ($urandom_range(0, 3) == 0) begin
                send_point(pick_coord(), pick_coord(), pick_coord(), 1'b0);
                send_point(pick_coord(), pick_coord(), pick_coord(), 1'b0);
                sent += 2;
            end
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: origin points and stray starts
                    if ($urandom_range(0, 1))
                        send_point(0, 0, pick_coord(), $urandom_range(0, 1));
                    else
                        send_point(pick_coord(), pick_coord(), pick_coord(), 1'b1);
                    sent++;
                end else begin
                    if ($urandom_range(0, 19) == 0)
                        send_point(0, 0, pick_coord(), 1'b1);
                    else
                        send_point(pick_coord(), pick_coord(), pick_coord(), 1'b1);
                    pts = $urandom_range(3, 15);
                    repeat (pts)
                        send_point(pick_coord(), pick_coord(), pick_coord(), 1'b0);
                    sent += pts + 1;
                end
            end
            calm = 1'b0;
        end

        settle();
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lmd_pkg.sv
rtl/core/lmd_mul.sv
rtl/core/lmd_cordic.sv
rtl/core/lidar_motion_deskew.sv
tb/lmd_deskew_checker.sv
tb/tb_lidar_motion_deskew.sv
